>>> rtl/matrix_exp_2x2_taylor_assert.svh
// Assertion macros for the matrix exponential RTL.
`ifndef MATRIX_EXP_2X2_TAYLOR_ASSERT_SVH
`define MATRIX_EXP_2X2_TAYLOR_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define MEXP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mexp_pkg.sv
// Package: widths, constants and sequencer states of the matrix exponential block.
package mexp_pkg;

    localparam int DATA_W        = 32;
    localparam int PROD_W        = 64;
    localparam int CNT_W         = 8;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIV_STEP_BITS = 4;

    localparam logic [CNT_W-1:0] TERM_COUNT_RST = 8'd100;

    localparam logic signed [PROD_W-1:0] I64_MAX = {1'b0, {(PROD_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] I64_MIN = {1'b1, {(PROD_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] I32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] I32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL0  = 7'b0000010,
        S_MUL1  = 7'b0000100,
        S_ADD   = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

endpackage

>>> rtl/mexp_div.sv
// Iterative unsigned divider, several quotient bits per cycle.
module mexp_div #(
    parameter int NUM_W     = mexp_pkg::DATA_W,
    parameter int DEN_W     = mexp_pkg::CNT_W,
    parameter int STEP_BITS = mexp_pkg::DIV_STEP_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int STEPS = NUM_W / STEP_BITS;
    localparam int SC_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic             r_busy;
    logic             r_done;
    logic [SC_W-1:0]  r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] n_num;
    logic [DEN_W-1:0] n_rem;

    // Run STEP_BITS restoring steps; the quotient shifts in where the dividend leaves
    always_comb begin
        logic [DEN_W:0]   trial;
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] num;
        rem = r_rem;
        num = r_num;
        for (int k = 0; k < STEP_BITS; k++) begin
            trial = {rem, num[NUM_W-1]};
            num   = {num[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, i_den}) begin
                trial  = trial - {1'b0, i_den};
                num[0] = 1'b1;
            end
            rem = trial[DEN_W-1:0];
        end
        n_num = num;
        n_rem = rem;
    end

    // Sequence the steps and flag the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SC_W'(STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Hold the working dividend and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

>>> rtl/matrix_exp_2x2_taylor.sv
// Top level: 2x2 matrix exponential by truncated Taylor series, signed fixed point.
// Usage:
//   Raise start for one cycle while busy is low to hand in one item, the four
//   elements of A on i_in_r*c*. Elements are signed with FRAC_BITS fraction bits.
//   The result E = exp(A) appears on o_exp_r*c* and o_overflow for exactly one
//   cycle, marked by o_valid; the receiver cannot stall, so it must take it then.
//   Each of the term_count terms runs, for each of the four elements, two passes
//   through the single 32x32 multiplier, an add, a shift and clamp, and a division
//   in the divider that retires four quotient bits per cycle. A new item may be
//   accepted in the cycle that shows the result, but not while an item is in flight.
//   term_count is written through i_cfg_valid / o_cfg_ready / i_cfg_data while
//   the block is idle; it resets to 100.
//   Reset (synchronous, active low) returns the sequencer to idle and drops
//   busy and o_valid; any item in flight is lost.
module matrix_exp_2x2_taylor #(
    parameter int FRAC_BITS = mexp_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [mexp_pkg::DATA_W-1:0]    i_in_r0c0,
    input  logic signed [mexp_pkg::DATA_W-1:0]    i_in_r0c1,
    input  logic signed [mexp_pkg::DATA_W-1:0]    i_in_r1c0,
    input  logic signed [mexp_pkg::DATA_W-1:0]    i_in_r1c1,
    output logic                                  o_valid,
    output logic signed [mexp_pkg::DATA_W-1:0]    o_exp_r0c0,
    output logic signed [mexp_pkg::DATA_W-1:0]    o_exp_r0c1,
    output logic signed [mexp_pkg::DATA_W-1:0]    o_exp_r1c0,
    output logic signed [mexp_pkg::DATA_W-1:0]    o_exp_r1c1,
    output logic                                  o_overflow,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mexp_pkg::CNT_W-1:0]            i_cfg_data
);

    localparam int DW = mexp_pkg::DATA_W;
    localparam int PW = mexp_pkg::PROD_W;
    localparam int CW = mexp_pkg::CNT_W;
    localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;

    mexp_pkg::t_state r_state, n_state;

    logic [CW-1:0]          r_term_count;
    logic signed [DW-1:0]   r_a    [4];
    logic signed [DW-1:0]   r_term [4];
    logic signed [DW-1:0]   r_tnew [4];
    logic signed [DW-1:0]   r_sum  [4];
    logic signed [PW:0]     r_acc;
    logic signed [PW-1:0]   r_prod;
    logic                   r_neg;
    logic                   r_ovf;
    logic [CW-1:0]          r_idx;
    logic [1:0]             r_elem;

    logic                   w_accept;
    logic                   w_second;
    logic signed [DW-1:0]   w_op_t;
    logic signed [DW-1:0]   w_op_a;
    logic signed [PW-1:0]   w_mul;
    logic                   w_ovf64;
    logic signed [PW-1:0]   w_sat64;
    logic signed [PW-1:0]   w_shift;
    logic                   w_ovf32;
    logic signed [DW-1:0]   w_t;
    logic [DW-1:0]          w_mag;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [DW-1:0]          w_quot;
    logic signed [DW-1:0]   w_q;
    logic signed [DW:0]     w_sum_x;
    logic                   w_ovf_sum;
    logic signed [DW-1:0]   w_sum_cl;
    logic                   w_last_elem;
    logic                   w_last_term;

    assign w_accept    = start && !busy;
    assign busy        = !(r_state == mexp_pkg::S_IDLE || r_state == mexp_pkg::S_DONE);
    assign o_cfg_ready = !busy;
    assign w_last_elem = (r_elem == 2'd3);
    assign w_last_term = (r_idx == r_term_count);

    // Pick the operands of the shared multiplier: T[r][k] * A[k][c]
    assign w_second = (r_state == mexp_pkg::S_MUL1);
    assign w_op_t   = r_term[{r_elem[1], w_second}];
    assign w_op_a   = r_a[{w_second, r_elem[0]}];
    assign w_mul    = w_op_t * w_op_a;

    // Saturate the product sum to 64 bits, floor shift, clamp to 32 bits
    assign w_ovf64 = (r_acc[PW] != r_acc[PW-1]);
    assign w_sat64 = w_ovf64 ? (r_acc[PW] ? mexp_pkg::I64_MIN : mexp_pkg::I64_MAX)
                             : r_acc[PW-1:0];
    assign w_shift = w_sat64 >>> FRAC_BITS;
    assign w_ovf32 = !((&w_shift[PW-1:DW-1]) || !(|w_shift[PW-1:DW-1]));
    assign w_t     = w_ovf32 ? (w_shift[PW-1] ? mexp_pkg::I32_MIN : mexp_pkg::I32_MAX)
                             : w_shift[DW-1:0];
    assign w_mag   = w_t[DW-1] ? (~w_t + 1'b1) : w_t;

    // Divide the term magnitude by the term index
    assign w_div_start = (r_state == mexp_pkg::S_SHIFT);

    mexp_div #(
        .NUM_W     (DW),
        .DEN_W     (CW),
        .STEP_BITS (mexp_pkg::DIV_STEP_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_mag),
        .i_den   (r_idx),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Restore the sign (toward zero) and add into the running sum with clamping
    assign w_q       = r_neg ? (~w_quot + 1'b1) : w_quot;
    assign w_sum_x   = {r_sum[r_elem][DW-1], r_sum[r_elem]} + {w_q[DW-1], w_q};
    assign w_ovf_sum = (w_sum_x[DW] != w_sum_x[DW-1]);
    assign w_sum_cl  = w_ovf_sum ? (w_sum_x[DW] ? mexp_pkg::I32_MIN : mexp_pkg::I32_MAX)
                                 : w_sum_x[DW-1:0];

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mexp_pkg::S_IDLE, mexp_pkg::S_DONE: begin
                if (w_accept) begin
                    n_state = (r_term_count == '0) ? mexp_pkg::S_DONE : mexp_pkg::S_MUL0;
                end else begin
                    n_state = mexp_pkg::S_IDLE;
                end
            end
            mexp_pkg::S_MUL0:  n_state = mexp_pkg::S_MUL1;
            mexp_pkg::S_MUL1:  n_state = mexp_pkg::S_ADD;
            mexp_pkg::S_ADD:   n_state = mexp_pkg::S_SHIFT;
            mexp_pkg::S_SHIFT: n_state = mexp_pkg::S_DIV;
            mexp_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = (w_last_elem && w_last_term) ? mexp_pkg::S_DONE
                                                           : mexp_pkg::S_MUL0;
                end
            end
            default: n_state = mexp_pkg::S_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mexp_pkg::S_IDLE;
            r_term_count <= mexp_pkg::TERM_COUNT_RST;
            r_idx        <= '0;
            r_elem       <= '0;
            r_ovf        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_term_count <= i_cfg_data;
            end
            if (w_accept) begin
                r_idx  <= CW'(1);
                r_elem <= '0;
                r_ovf  <= 1'b0;
            end else begin
                unique case (r_state)
                    mexp_pkg::S_SHIFT: begin
                        if (w_ovf64 || w_ovf32) begin
                            r_ovf <= 1'b1;
                        end
                    end
                    mexp_pkg::S_DIV: begin
                        if (w_div_done) begin
                            if (w_ovf_sum) begin
                                r_ovf <= 1'b1;
                            end
                            r_elem <= r_elem + 1'b1;
                            if (w_last_elem && !w_last_term) begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Hold the datapath: operands, accumulator, term and sum matrices
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a[0]    <= i_in_r0c0;
            r_a[1]    <= i_in_r0c1;
            r_a[2]    <= i_in_r1c0;
            r_a[3]    <= i_in_r1c1;
            r_sum[0]  <= ONE;
            r_sum[1]  <= '0;
            r_sum[2]  <= '0;
            r_sum[3]  <= ONE;
            r_term[0] <= ONE;
            r_term[1] <= '0;
            r_term[2] <= '0;
            r_term[3] <= ONE;
        end else begin
            unique case (r_state)
                mexp_pkg::S_MUL0: r_acc <= {w_mul[PW-1], w_mul};
                mexp_pkg::S_MUL1: r_prod <= w_mul;
                mexp_pkg::S_ADD:  r_acc <= r_acc + {r_prod[PW-1], r_prod};
                mexp_pkg::S_SHIFT: r_neg <= w_t[DW-1];
                mexp_pkg::S_DIV: begin
                    if (w_div_done) begin
                        r_tnew[r_elem] <= w_q;
                        r_sum[r_elem]  <= w_sum_cl;
                        // Commit the new term once all four products used the old one
                        if (w_last_elem) begin
                            r_term[0] <= r_tnew[0];
                            r_term[1] <= r_tnew[1];
                            r_term[2] <= r_tnew[2];
                            r_term[3] <= w_q;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid    = (r_state == mexp_pkg::S_DONE);
    assign o_exp_r0c0 = r_sum[0];
    assign o_exp_r0c1 = r_sum[1];
    assign o_exp_r1c0 = r_sum[2];
    assign o_exp_r1c1 = r_sum[3];
    assign o_overflow = r_ovf;

`include "matrix_exp_2x2_taylor_assert.svh"

    `MEXP_ASSERT_NOW(a_div_done_in_div, w_div_done, r_state == mexp_pkg::S_DIV, "stray divide done")
    `MEXP_ASSERT_NEXT(a_accept_goes_busy, w_accept && r_term_count != '0, busy, "idle after accept")
    `MEXP_ASSERT_NOW(a_idx_in_range, busy, r_idx != '0 && r_idx <= r_term_count, "bad term index")

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the 2x2 matrix exponential block: directed corners, then random matrices.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W      = mexp_pkg::DATA_W;
    localparam int PROD_W      = mexp_pkg::PROD_W;
    localparam int CNT_W       = mexp_pkg::CNT_W;
    localparam int FRAC        = mexp_pkg::FRAC_BITS_DEF;
    localparam int IDLE_PCT    = 34;
    localparam int MAX_GAP     = 60;
    // Slowest item runs 255 terms plus the longest sender gap; allow several times that.
    localparam int STALL_LIMIT = 60000;
    localparam int SETTLE      = 20;
    localparam int REPORT_MAX  = 10;

    localparam logic signed [DATA_W-1:0] I32_MAX = mexp_pkg::I32_MAX;
    localparam logic signed [DATA_W-1:0] I32_MIN = mexp_pkg::I32_MIN;
    localparam logic signed [PROD_W-1:0] I64_MAX = mexp_pkg::I64_MAX;
    localparam logic signed [PROD_W-1:0] I64_MIN = mexp_pkg::I64_MIN;
    localparam logic [CNT_W-1:0]         TERM_COUNT_RST = mexp_pkg::TERM_COUNT_RST;

    localparam logic signed [DATA_W-1:0] ONE  = 32'sd1 <<< FRAC;
    localparam logic signed [DATA_W-1:0] HALF = 32'sd1 <<< (FRAC - 1);
    localparam longint                   ONE_L = longint'(1) <<< FRAC;
    localparam logic signed [DATA_W-1:0] CORNERS [5] = '{I32_MAX, I32_MIN, '0, '1, ONE};

    typedef struct packed {
        logic signed [DATA_W-1:0] r0c0;
        logic signed [DATA_W-1:0] r0c1;
        logic signed [DATA_W-1:0] r1c0;
        logic signed [DATA_W-1:0] r1c1;
    } t_matrix;

    typedef struct packed {
        t_matrix m;
        logic    ovf;
    } t_exp_result;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    t_matrix            a_drv       = '0;
    logic               i_cfg_valid = 1'b0;
    logic [CNT_W-1:0]   i_cfg_data  = '0;
    logic               busy;
    logic               o_valid;
    logic               o_overflow;
    logic               o_cfg_ready;
    logic signed [DATA_W-1:0] o_exp_r0c0, o_exp_r0c1, o_exp_r1c0, o_exp_r1c1;

    // Predictor state and run statistics
    t_exp_result        expected_exps [$];
    logic [CNT_W-1:0]   term_count_now = TERM_COUNT_RST;
    logic               idle_on        = 1'b1;
    int                 items_sent     = 0;
    int                 results_seen   = 0;
    int                 saturated_seen = 0;
    int                 cfg_writes     = 0;
    int                 idle_cycles    = 0;
    int                 fail_count     = 0;
    int                 stall_cycles   = 0;

    matrix_exp_2x2_taylor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in_r0c0   (a_drv.r0c0),
        .i_in_r0c1   (a_drv.r0c1),
        .i_in_r1c0   (a_drv.r1c0),
        .i_in_r1c1   (a_drv.r1c1),
        .o_valid     (o_valid),
        .o_exp_r0c0  (o_exp_r0c0),
        .o_exp_r0c1  (o_exp_r0c1),
        .o_exp_r1c0  (o_exp_r1c0),
        .o_exp_r1c1  (o_exp_r1c1),
        .o_overflow  (o_overflow),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Clamp to the 32-bit range and flag saturation
    function automatic longint clamp_word(input longint v, inout logic ovf);
        if (v > longint'(I32_MAX)) begin
            ovf = 1'b1;
            return longint'(I32_MAX);
        end
        if (v < longint'(I32_MIN)) begin
            ovf = 1'b1;
            return longint'(I32_MIN);
        end
        return v;
    endfunction

    // Truncated Taylor series of exp(A) in fixed point, with saturation tracking
    function automatic t_exp_result taylor_exp(input t_matrix a_in, input int unsigned n_terms);
        longint                   a [4];
        longint                   e [4];
        longint                   t [4];
        longint                   p [4];
        logic signed [PROD_W+1:0] dot;
        longint                   dot_sat;
        logic                     ovf;
        t_exp_result              res;
        a[0] = a_in.r0c0;
        a[1] = a_in.r0c1;
        a[2] = a_in.r1c0;
        a[3] = a_in.r1c1;
        e = '{ONE_L, 0, 0, ONE_L};
        t = e;
        ovf = 1'b0;
        for (int i = 1; i <= n_terms; i++) begin
            for (int r = 0; r < 2; r++) begin
                for (int c = 0; c < 2; c++) begin
                    dot = (PROD_W+2)'(t[r*2]) * (PROD_W+2)'(a[c])
                        + (PROD_W+2)'(t[r*2+1]) * (PROD_W+2)'(a[2+c]);
                    // Saturate the exact dot product to 64 bits
                    if (dot[PROD_W+1:PROD_W-1] != {3{dot[PROD_W-1]}}) begin
                        ovf = 1'b1;
                        dot_sat = dot[PROD_W+1] ? I64_MIN : I64_MAX;
                    end else begin
                        dot_sat = dot[PROD_W-1:0];
                    end
                    // Arithmetic shift rounds toward minus infinity
                    p[r*2+c] = clamp_word(dot_sat >>> FRAC, ovf);
                end
            end
            // Divide by the term index (toward zero) and accumulate
            for (int k = 0; k < 4; k++) begin
                t[k] = p[k] / longint'(i);
                e[k] = clamp_word(e[k] + t[k], ovf);
            end
        end
        res.m.r0c0 = e[0][DATA_W-1:0];
        res.m.r0c1 = e[1][DATA_W-1:0];
        res.m.r1c0 = e[2][DATA_W-1:0];
        res.m.r1c1 = e[3][DATA_W-1:0];
        res.ovf    = ovf;
        return res;
    endfunction

    function automatic t_matrix mat(input logic signed [DATA_W-1:0] a00, a01, a10, a11);
        mat = '{a00, a01, a10, a11};
    endfunction

    // Mostly values near the interesting range, with full-width and corner values mixed in
    function automatic logic signed [DATA_W-1:0] random_element();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: v = $signed($urandom_range(262143)) - 32'sd131072;
            5, 6:          v = $signed($urandom_range(8388607)) - 32'sd4194304;
            7, 8:          v = $urandom;
            default:       v = CORNERS[$urandom_range(4)];
        endcase
        return v;
    endfunction

    function automatic t_matrix random_matrix();
        t_matrix m;
        m = mat(random_element(), random_element(), random_element(), random_element());
        // Hold some items to diagonal form
        if ($urandom_range(4) == 0) begin
            m.r0c1 = '0;
            m.r1c0 = '0;
        end
        return m;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got)
            note_failure($sformatf("%s mismatch: expected %h, got %h", name, want, got));
    endtask

    // Random sender gap
    task automatic maybe_idle();
        int gap;
        if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            gap = $urandom_range(1, MAX_GAP);
            idle_cycles += gap;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hand in one item and queue its expected exponential at the accept edge
    task automatic send_matrix(input t_matrix a);
        int gap;
        // Drop start for a random gap before some items
        if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            gap = $urandom_range(1, MAX_GAP);
            idle_cycles += gap;
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        a_drv <= a;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_exps.push_back(taylor_exp(a, term_count_now));
        items_sent++;
    endtask

    task automatic wait_results_drained();
        while (expected_exps.size() != 0) @(posedge i_clk);
    endtask

    // Drop start and let the block finish everything in flight
    task automatic end_batch();
        start <= 1'b0;
        wait_results_drained();
    endtask

    task automatic set_term_count(input logic [CNT_W-1:0] n);
        wait_results_drained();
        maybe_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= n;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        term_count_now = n;
        cfg_writes++;
    endtask

    // Compare each result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_exp_result want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (o_overflow)
                saturated_seen++;
            if (expected_exps.size() == 0) begin
                note_failure($sformatf("unexpected result %h %h %h %h ovf %b",
                                       o_exp_r0c0, o_exp_r0c1, o_exp_r1c0, o_exp_r1c1,
                                       o_overflow));
            end else begin
                want = expected_exps.pop_front();
                check_field("exp_r0c0", want.m.r0c0, o_exp_r0c0);
                check_field("exp_r0c1", want.m.r0c1, o_exp_r0c1);
                check_field("exp_r1c0", want.m.r1c0, o_exp_r1c0);
                check_field("exp_r1c1", want.m.r1c1, o_exp_r1c1);
                check_field("overflow", {{(DATA_W-1){1'b0}}, want.ovf},
                            {{(DATA_W-1){1'b0}}, o_overflow});
            end
        end
    end

    // Stop the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no activity for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_exps.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Items under the reset term count
    task automatic test_reset_term_count();
        send_matrix(mat('0, '0, '0, '0));
        send_matrix(mat(HALF, '0, '0, -HALF));
        send_matrix(mat('0, ONE, -ONE, '0));
        end_batch();
    endtask

    // Extreme and patterned elements over a short series
    task automatic test_element_extremes();
        set_term_count(8'd2);
        send_matrix(mat(I32_MAX, I32_MAX, I32_MAX, I32_MAX));
        send_matrix(mat(I32_MIN, I32_MIN, I32_MIN, I32_MIN));
        send_matrix(mat('1, '1, '1, '1));
        send_matrix(mat(I32_MAX, I32_MIN, I32_MIN, I32_MAX));
        send_matrix(mat(32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA));
        send_matrix(mat('0, ONE, '0, '0));
        send_matrix(mat(ONE, '0, '0, ONE));
        send_matrix(mat(32'sd1, -32'sd1, 32'sd1, -32'sd1));
        end_batch();
    endtask

    task automatic test_single_term();
        set_term_count(8'd1);
        send_matrix(mat(I32_MIN, I32_MAX, I32_MAX, I32_MIN));
        send_matrix(mat(HALF, ONE, -ONE, HALF));
        end_batch();
    endtask

    // Zero term count returns the identity with no saturation
    task automatic test_zero_terms();
        set_term_count(8'd0);
        send_matrix(mat(I32_MAX, I32_MAX, I32_MIN, I32_MIN));
        send_matrix(random_matrix());
        end_batch();
    endtask

    task automatic test_longest_series();
        set_term_count(8'd255);
        send_matrix(mat(HALF >>> 1, '0, '0, HALF >>> 1));
        send_matrix(mat(I32_MAX, I32_MIN, I32_MAX, I32_MIN));
        end_batch();
    endtask

    // Random matrices in batches, each batch under its own small term count
    task automatic test_random_matrices();
        int n_terms;
        for (int batch = 0; batch < 10; batch++) begin
            n_terms = (batch == 0) ? 1 : (batch == 9) ? 16 : $urandom_range(2, 12);
            set_term_count(n_terms[CNT_W-1:0]);
            // One batch runs back to back with no gaps at all
            idle_on = (batch != 4);
            repeat (28) send_matrix(random_matrix());
            end_batch();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_term_count();
        test_element_extremes();
        test_single_term();
        test_zero_terms();
        test_longest_series();
        test_random_matrices();

        wait_results_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (expected_exps.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_exps.size()));

        $display("Run covered %0d matrices over %0d term-count writes (0, 1, 2, 255, reset value",
                 items_sent, cfg_writes);
        $display("and random small counts); %0d results checked, %0d saturated, %0d gap cycles.",
                 results_seen, saturated_seen, idle_cycles);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches in total", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
